// ===== rtl/core/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths for the vector normalization datapath.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int UNIT_W = 32;
  localparam int QUOT_FRAC = 60;
  localparam int QUOT_W = QUOT_FRAC + 1;

endpackage

// ===== rtl/core/vn_square.sv =====
// ----------------------------------------------------------------------------
// vn_square
// One component lane: magnitude and sign, then a split square over two stages.
// ----------------------------------------------------------------------------
module vn_square #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   comp,
  output logic [2*W-1:0] sq,
  output logic           neg
);

  localparam int LO_W = W / 2;
  localparam int HI_W = W - LO_W;

  logic [W-1:0]         mag;
  logic                 neg_a;
  logic                 neg_b;
  logic [2*HI_W-1:0]    p_hh;
  logic [HI_W+LO_W-1:0] p_hl;
  logic [2*LO_W-1:0]    p_ll;

  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= comp[W-1] ? (~comp + W'(1)) : comp;
      neg_a <= comp[W-1];
      p_hh  <= mag[W-1:LO_W] * mag[W-1:LO_W];
      p_hl  <= mag[W-1:LO_W] * mag[LO_W-1:0];
      p_ll  <= mag[LO_W-1:0] * mag[LO_W-1:0];
      neg_b <= neg_a;
      sq    <= ((2*W)'(p_hh) << (2*LO_W)) + ((2*W)'(p_hl) << (LO_W + 1))
               + (2*W)'(p_ll);
      neg   <= neg_b;
    end
  end

endmodule

// ===== rtl/core/vn_isqrt.sv =====
// ----------------------------------------------------------------------------
// vn_isqrt
// Pipelined integer square root, one root bit per stage, with a tag beside it.
// ----------------------------------------------------------------------------
module vn_isqrt #(
  parameter int IN_W = 66,
  parameter int TAG_W = 1,
  localparam int RT_W = (IN_W + 1) / 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [IN_W-1:0]  in_data,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [RT_W-1:0]  out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int PW = 2 * RT_W;
  localparam int RW = RT_W + 2;

  logic [RT_W:0]    v;
  logic [PW-1:0]    xs   [RT_W];
  logic [RW-1:0]    rem  [RT_W];
  logic [RT_W-1:0]  root [RT_W+1];
  logic [TAG_W-1:0] tag  [RT_W+1];

  assign v[0]    = in_valid;
  assign xs[0]   = PW'(in_data);
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = in_tag;

  for (genvar g = 0; g < RT_W; g++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    assign rem_sh = {rem[g][RW-3:0], xs[g][PW-1 -: 2]};
    assign trial  = {root[g], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[g+1] <= {root[g][RT_W-2:0], ge};
        tag[g+1]  <= tag[g];
      end
    end

    if (g + 1 < RT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          xs[g+1]  <= xs[g] << 2;
          rem[g+1] <= ge ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign out_valid = v[RT_W];
  assign out_root  = root[RT_W];
  assign out_tag   = tag[RT_W];

endmodule

// ===== rtl/core/vn_divide.sv =====
// ----------------------------------------------------------------------------
// vn_divide
// Pipelined restoring division of num * 2^QUOT_FRAC by den, num <= den.
// ----------------------------------------------------------------------------
module vn_divide #(
  parameter int SW = 66,
  parameter int TAG_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SW-1:0]     num,
  input  logic [SW-1:0]     den,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [vn_pkg::QUOT_W-1:0] quot,
  output logic [TAG_W-1:0]  out_tag
);
  import vn_pkg::*;

  logic [QUOT_W:0]   v;
  logic [SW:0]       r   [QUOT_W];
  logic [SW-1:0]     s   [QUOT_W];
  logic [QUOT_W-1:0] q   [QUOT_W+1];
  logic [TAG_W-1:0]  tag [QUOT_W+1];

  assign v[0]   = in_valid;
  assign r[0]   = {1'b0, num};
  assign s[0]   = den;
  assign q[0]   = '0;
  assign tag[0] = in_tag;

  for (genvar g = 0; g < QUOT_W; g++) begin : g_stage
    logic [SW:0] rs;
    logic        ge;

    if (g == 0) begin : g_first
      assign rs = r[g];
    end else begin : g_shift
      assign rs = {r[g][SW-1:0], 1'b0};
    end
    assign ge = rs >= {1'b0, s[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[g+1]   <= {q[g][QUOT_W-2:0], ge};
        tag[g+1] <= tag[g];
      end
    end

    if (g + 1 < QUOT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r[g+1] <= ge ? (rs - {1'b0, s[g]}) : rs;
          s[g+1] <= s[g];
        end
      end
    end
  end

  assign out_valid = v[QUOT_W];
  assign quot      = q[QUOT_W];
  assign out_tag   = tag[QUOT_W];

endmodule

// ===== rtl/core/vec3_normalize.sv =====
// ----------------------------------------------------------------------------
// vec3_normalize
// Three lanes square the components; a merge stage sums them and takes the
// length root; the lanes then divide by the sum and take the unit root.
// Pipeline: three square stages, one sum, one per length root bit, 61 divide
// stages, 31 unit root stages, one output register. Throughput: one beat per
// cycle, the pipeline holds whenever the output register is full and not taken.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module vec3_normalize #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vec_x, vec_y, vec_z
  input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // unit_x, unit_y, unit_z, length
  output logic [((3*vn_pkg::UNIT_W+COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // is_zero
  output logic [0:0] m_axis_tuser
);
  import vn_pkg::*;

  localparam int W      = COMPONENT_WIDTH;
  localparam int SQ_W   = 2 * W;
  localparam int SUM_W  = 2 * W + 2;
  localparam int LEN_W  = W + 1;
  localparam int OD_W   = ((3 * UNIT_W + W + 7) / 8) * 8;
  localparam int LT_W   = 1 + 3 + 3 * SQ_W + SUM_W;
  localparam int T0_W   = 2 + W;
  localparam int ROOT_W = (QUOT_W + 1) / 2;

  logic             en;
  logic [2:0]       v_front;
  logic [SQ_W-1:0]  sq   [3];
  logic             neg  [3];
  logic [SQ_W-1:0]  sq_d [3];
  logic [2:0]       neg_d;
  logic [SUM_W-1:0] sum_d;
  logic             v_d;

  logic             len_valid;
  logic [LEN_W-1:0] len_root;
  logic [LT_W-1:0]  len_tag;
  logic             zero_l;
  logic [2:0]       neg_l;
  logic [SQ_W-1:0]  sq_l [3];
  logic [SUM_W-1:0] sum_l;

  logic [2:0]        div_valid;
  logic [QUOT_W-1:0] quot [3];
  logic [T0_W-1:0]   div_tag0;
  logic [0:0]        div_tag12 [1:2];

  logic [2:0]        rt_valid;
  logic [ROOT_W-1:0] rt [3];
  logic [T0_W-1:0]   rt_tag0;
  logic [0:0]        rt_tag12 [1:2];
  logic [2:0]        rt_neg;

  logic [UNIT_W-1:0] unit [3];
  logic [W-1:0]      length;
  logic              is_zero;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front <= '0;
      v_d     <= 1'b0;
    end else if (en) begin
      v_front <= {v_front[1:0], s_axis_tvalid};
      v_d     <= v_front[2];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vn_square #(.W(W)) u_square (
      .clk  (clk),
      .en   (en),
      .comp (s_axis_tdata[l*W +: W]),
      .sq   (sq[l]),
      .neg  (neg[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_d <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      for (int l = 0; l < 3; l++) begin
        sq_d[l]  <= sq[l];
        neg_d[l] <= neg[l];
      end
    end
  end

  vn_isqrt #(.IN_W(SUM_W), .TAG_W(LT_W)) u_len_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_d),
    .in_data   (sum_d),
    .in_tag    ({sum_d == '0, neg_d, sq_d[2], sq_d[1], sq_d[0], sum_d}),
    .out_valid (len_valid),
    .out_root  (len_root),
    .out_tag   (len_tag)
  );

  assign {zero_l, neg_l, sq_l[2], sq_l[1], sq_l[0], sum_l} = len_tag;

  vn_divide #(.SW(SUM_W), .TAG_W(T0_W)) u_div0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (len_valid),
    .num       (SUM_W'(sq_l[0])),
    .den       (sum_l),
    .in_tag    ({zero_l, len_root[W-1:0], neg_l[0]}),
    .out_valid (div_valid[0]),
    .quot      (quot[0]),
    .out_tag   (div_tag0)
  );

  vn_isqrt #(.IN_W(QUOT_W), .TAG_W(T0_W)) u_rt0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid[0]),
    .in_data   (quot[0]),
    .in_tag    (div_tag0),
    .out_valid (rt_valid[0]),
    .out_root  (rt[0]),
    .out_tag   (rt_tag0)
  );

  for (genvar l = 1; l < 3; l++) begin : g_back
    vn_divide #(.SW(SUM_W), .TAG_W(1)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (len_valid),
      .num       (SUM_W'(sq_l[l])),
      .den       (sum_l),
      .in_tag    (neg_l[l]),
      .out_valid (div_valid[l]),
      .quot      (quot[l]),
      .out_tag   (div_tag12[l])
    );

    vn_isqrt #(.IN_W(QUOT_W), .TAG_W(1)) u_rt (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_valid[l]),
      .in_data   (quot[l]),
      .in_tag    (div_tag12[l]),
      .out_valid (rt_valid[l]),
      .out_root  (rt[l]),
      .out_tag   (rt_tag12[l])
    );
  end

  assign rt_neg = {rt_tag12[2][0], rt_tag12[1][0], rt_tag0[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= rt_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_zero <= rt_tag0[T0_W-1];
      length  <= rt_tag0[T0_W-1] ? '0 : rt_tag0[W:1];
      for (int l = 0; l < 3; l++) begin
        if (rt_tag0[T0_W-1]) begin
          unit[l] <= '0;
        end else if (rt_neg[l]) begin
          unit[l] <= ~UNIT_W'(rt[l]) + UNIT_W'(1);
        end else begin
          unit[l] <= UNIT_W'(rt[l]);
        end
      end
    end
  end

  assign m_axis_tdata = OD_W'({length, unit[2], unit[1], unit[0]});
  assign m_axis_tuser = is_zero;

  a_zero_units: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && is_zero |-> unit[0] == '0 && unit[1] == '0 && unit[2] == '0
      && length == '0)
    else $error("zero vector produced nonzero result");

  a_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !is_zero |-> length != '0)
    else $error("nonzero vector produced zero length");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    rt_valid[0] == rt_valid[1] && rt_valid[1] == rt_valid[2]
      && div_valid[0] == div_valid[1] && div_valid[1] == div_valid[2])
    else $error("lanes out of step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(unit[0]) && $stable(length)
      && $stable(is_zero))
    else $error("result changed while stalled");

endmodule
